// File: rtl/core/assert_macros.svh
// Assertion helpers included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define DMSP_ASSERT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define DMSP_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/core/dmsp_pkg.sv
`timescale 1ns / 1ps
package dmsp_pkg;

    localparam int KIND_W    = 5;
    localparam int SECTION_W = 3;
    localparam int VALUE_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ID        = 5'd0;
    localparam logic [KIND_W-1:0] KIND_FLAGS     = 5'd1;
    localparam logic [KIND_W-1:0] KIND_QDCOUNT   = 5'd2;
    localparam logic [KIND_W-1:0] KIND_ANCOUNT   = 5'd3;
    localparam logic [KIND_W-1:0] KIND_NSCOUNT   = 5'd4;
    localparam logic [KIND_W-1:0] KIND_ARCOUNT   = 5'd5;
    localparam logic [KIND_W-1:0] KIND_LABEL_LEN = 5'd6;
    localparam logic [KIND_W-1:0] KIND_NAME_BYTE = 5'd7;
    localparam logic [KIND_W-1:0] KIND_POINTER   = 5'd8;
    localparam logic [KIND_W-1:0] KIND_NAME_END  = 5'd9;
    localparam logic [KIND_W-1:0] KIND_TYPE      = 5'd10;
    localparam logic [KIND_W-1:0] KIND_CLASS     = 5'd11;
    localparam logic [KIND_W-1:0] KIND_TTL       = 5'd12;
    localparam logic [KIND_W-1:0] KIND_RDLENGTH  = 5'd13;
    localparam logic [KIND_W-1:0] KIND_RDATA     = 5'd14;
    localparam logic [KIND_W-1:0] KIND_DONE      = 5'd15;
    localparam logic [KIND_W-1:0] KIND_ERROR     = 5'd16;

    // Sections
    localparam logic [SECTION_W-1:0] SEC_HEADER     = 3'd0;
    localparam logic [SECTION_W-1:0] SEC_QUESTION   = 3'd1;
    localparam logic [SECTION_W-1:0] SEC_ANSWER     = 3'd2;
    localparam logic [SECTION_W-1:0] SEC_AUTHORITY  = 3'd3;
    localparam logic [SECTION_W-1:0] SEC_ADDITIONAL = 3'd4;

    // Error codes
    localparam logic [VALUE_W-1:0] ERR_LABEL = 32'd0;
    localparam logic [VALUE_W-1:0] ERR_NAME  = 32'd1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LABEL_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NAME_LIMIT  = 2'd1;

    localparam logic [5:0] LABEL_LIMIT_RESET = 6'd63;
    localparam logic [7:0] NAME_LIMIT_RESET  = 8'd255;

    localparam logic [7:0] PTR_MARK = 8'hC0;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [SECTION_W-1:0] section;
        logic [VALUE_W-1:0]   value;
    } t_result;

endpackage

// File: rtl/core/dns_message_stream_parser.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake               | Payload
// in       | input     | i_in_valid / o_in_ready | i_data_byte, i_message_start
// out      | output    | o_out_valid / i_out_ready | o_kind, o_section, o_value, flag fields
// cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One byte is parsed per cycle while o_in_ready is high; its results are written
// to a four-entry output queue at the same edge and are read out from its head.
// A byte yields up to two results (a closing field plus done), so o_in_ready
// needs two free queue slots; one result per byte keeps full rate with no output stall.
// Reset (synchronous, active low) drops parsing to idle, empties the queue and
// restores label_limit 63 and name_limit 255. The cfg channel is always ready.
module dns_message_stream_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_message_start,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [dmsp_pkg::KIND_W-1:0]      o_kind,
    output logic [dmsp_pkg::SECTION_W-1:0]   o_section,
    output logic [dmsp_pkg::VALUE_W-1:0]     o_value,
    output logic                             o_is_response,
    output logic [3:0]                       o_op_code,
    output logic                             o_authoritative,
    output logic                             o_truncated,
    output logic                             o_recursion_desired,
    output logic                             o_recursion_available,
    output logic [2:0]                       o_reserved_bits,
    output logic [3:0]                       o_response_code,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dmsp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dmsp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import dmsp_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ID, PH_FLAGS, PH_QD, PH_AN, PH_NS, PH_AR, PH_NAME, PH_LABEL,
        PH_PTR, PH_TYPE, PH_CLASS, PH_TTL, PH_RDLEN, PH_RDATA, PH_DONE, PH_ERROR
    } t_phase;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Parse state
    t_phase       r_phase, c_phase, n_phase;
    logic [2:0]   r_section, c_section, n_section;
    logic [2:0]   r_fcount, c_fcount, n_fcount;
    logic [31:0]  r_acc, c_acc, n_acc;
    logic [15:0]  r_qd, c_qd, n_qd;
    logic [15:0]  r_an, c_an, n_an;
    logic [15:0]  r_ns, c_ns, n_ns;
    logic [15:0]  r_ar, c_ar, n_ar;
    logic [8:0]   r_name_len, c_name_len, n_name_len;
    logic [5:0]   r_label_left, c_label_left, n_label_left;
    logic [15:0]  r_rdata_left, c_rdata_left, n_rdata_left;
    logic [5:0]   r_label_limit;
    logic [7:0]   r_name_limit;

    // Output queue
    t_result             r_q [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]     r_q_count;

    logic         in_fire, out_fire;
    logic [1:0]   res_cnt;
    t_result      res0, res1;
    logic [31:0]  acc_shift;
    logic [2:0]   fcount_inc;
    logic [2:0]   field_width;
    logic [9:0]   name_len_sum;
    logic [15:0]  cur_count, cur_dec;
    logic         do_enter;
    logic [2:0]   enter_first;
    t_result      head;

    assign in_fire    = i_in_valid & o_in_ready;
    assign out_fire   = o_out_valid & i_out_ready;
    assign o_in_ready = (r_q_count <= (QPTR_W+1)'(QDEPTH - 2));
    assign o_cfg_ready = 1'b1;

    always_comb begin
        // a start byte wipes the parse and is taken as the first ID byte
        if (i_message_start) begin
            c_phase = PH_ID;       c_section = SEC_HEADER; c_fcount = '0;
            c_acc = '0;            c_qd = '0;  c_an = '0;  c_ns = '0;  c_ar = '0;
            c_name_len = '0;       c_label_left = '0;      c_rdata_left = '0;
        end else begin
            c_phase = r_phase;     c_section = r_section;  c_fcount = r_fcount;
            c_acc = r_acc;         c_qd = r_qd; c_an = r_an; c_ns = r_ns; c_ar = r_ar;
            c_name_len = r_name_len; c_label_left = r_label_left;
            c_rdata_left = r_rdata_left;
        end

        n_phase = c_phase;     n_section = c_section;  n_fcount = c_fcount;
        n_acc = c_acc;         n_qd = c_qd; n_an = c_an; n_ns = c_ns; n_ar = c_ar;
        n_name_len = c_name_len; n_label_left = c_label_left;
        n_rdata_left = c_rdata_left;

        res_cnt = 2'd0;
        res0 = '{kind: KIND_ID, section: c_section, value: '0};
        res1 = '{kind: KIND_DONE, section: c_section, value: '0};
        do_enter = 1'b0;
        enter_first = c_section;

        acc_shift   = {c_acc[23:0], i_data_byte};
        fcount_inc  = c_fcount + 3'd1;
        field_width = (c_phase == PH_TTL) ? 3'd4 : 3'd2;
        name_len_sum = {1'b0, c_name_len} + {2'b0, i_data_byte} + 10'd1;

        unique case (c_section)
            SEC_QUESTION:   cur_count = c_qd;
            SEC_ANSWER:     cur_count = c_an;
            SEC_AUTHORITY:  cur_count = c_ns;
            SEC_ADDITIONAL: cur_count = c_ar;
            default:        cur_count = '0;
        endcase
        cur_dec = (cur_count != '0) ? cur_count - 16'd1 : cur_count;

        unique case (c_phase)
            PH_IDLE, PH_DONE, PH_ERROR: begin
            end
            PH_NAME: begin
                res_cnt = 2'd1;
                if (i_data_byte == 8'd0) begin
                    res0 = '{kind: KIND_NAME_END, section: c_section,
                             value: {23'd0, c_name_len} + 32'd1};
                    n_phase = PH_TYPE;
                    n_fcount = '0;
                    n_acc = '0;
                end else if (c_section != SEC_QUESTION
                             && (i_data_byte & PTR_MARK) == PTR_MARK) begin
                    res_cnt = 2'd0;
                    n_acc = {26'd0, i_data_byte[5:0]};
                    n_phase = PH_PTR;
                end else if (i_data_byte > {2'b0, r_label_limit}) begin
                    res0 = '{kind: KIND_ERROR, section: c_section, value: ERR_LABEL};
                    n_phase = PH_ERROR;
                end else if (name_len_sum > {2'b0, r_name_limit}) begin
                    res0 = '{kind: KIND_ERROR, section: c_section, value: ERR_NAME};
                    n_phase = PH_ERROR;
                end else begin
                    res0 = '{kind: KIND_LABEL_LEN, section: c_section,
                             value: {24'd0, i_data_byte}};
                    n_name_len = name_len_sum[8:0];
                    n_label_left = i_data_byte[5:0];
                    n_phase = PH_LABEL;
                end
            end
            PH_LABEL: begin
                res_cnt = 2'd1;
                res0 = '{kind: KIND_NAME_BYTE, section: c_section,
                         value: {24'd0, i_data_byte}};
                n_label_left = c_label_left - 6'd1;
                if (n_label_left == '0) begin
                    n_phase = PH_NAME;
                end
            end
            PH_PTR: begin
                res_cnt = 2'd1;
                res0 = '{kind: KIND_POINTER, section: c_section,
                         value: {18'd0, c_acc[5:0], i_data_byte}};
                n_acc = '0;
                n_fcount = '0;
                n_phase = PH_TYPE;
            end
            PH_RDATA: begin
                res_cnt = 2'd1;
                res0 = '{kind: KIND_RDATA, section: c_section,
                         value: {24'd0, i_data_byte}};
                n_rdata_left = c_rdata_left - 16'd1;
                if (n_rdata_left == '0) begin
                    do_enter = 1'b1;
                end
            end
            default: begin
                // big-endian fixed fields: ID, flags, counts, type, class, TTL, RDLENGTH
                if (fcount_inc < field_width) begin
                    n_acc = acc_shift;
                    n_fcount = fcount_inc;
                end else begin
                    n_acc = '0;
                    n_fcount = '0;
                    res_cnt = 2'd1;
                    res0.value = acc_shift;
                    unique case (c_phase)
                        PH_ID: begin
                            res0.kind = KIND_ID;  res0.section = SEC_HEADER;
                            n_phase = PH_FLAGS;
                        end
                        PH_FLAGS: begin
                            res0.kind = KIND_FLAGS;  res0.section = SEC_HEADER;
                            n_phase = PH_QD;
                        end
                        PH_QD: begin
                            res0.kind = KIND_QDCOUNT;  res0.section = SEC_HEADER;
                            n_qd = acc_shift[15:0];
                            n_phase = PH_AN;
                        end
                        PH_AN: begin
                            res0.kind = KIND_ANCOUNT;  res0.section = SEC_HEADER;
                            n_an = acc_shift[15:0];
                            n_phase = PH_NS;
                        end
                        PH_NS: begin
                            res0.kind = KIND_NSCOUNT;  res0.section = SEC_HEADER;
                            n_ns = acc_shift[15:0];
                            n_phase = PH_AR;
                        end
                        PH_AR: begin
                            res0.kind = KIND_ARCOUNT;  res0.section = SEC_HEADER;
                            n_ar = acc_shift[15:0];
                            do_enter = 1'b1;
                            enter_first = SEC_QUESTION;
                        end
                        PH_TYPE: begin
                            res0.kind = KIND_TYPE;
                            n_phase = PH_CLASS;
                        end
                        PH_CLASS: begin
                            res0.kind = KIND_CLASS;
                            if (c_section == SEC_QUESTION) begin
                                do_enter = 1'b1;
                            end else begin
                                n_phase = PH_TTL;
                            end
                        end
                        PH_TTL: begin
                            res0.kind = KIND_TTL;
                            n_phase = PH_RDLEN;
                        end
                        PH_RDLEN: begin
                            res0.kind = KIND_RDLENGTH;
                            n_rdata_left = acc_shift[15:0];
                            if (acc_shift[15:0] == '0) begin
                                do_enter = 1'b1;
                            end else begin
                                n_phase = PH_RDATA;
                            end
                        end
                        default: begin
                            res_cnt = 2'd0;
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end
        endcase

        // close the record (count down) and move to the current or next non-empty section, else to done
        if (do_enter) begin
            if (enter_first == c_section) begin
                unique case (c_section)
                    SEC_QUESTION:   n_qd = cur_dec;
                    SEC_ANSWER:     n_an = cur_dec;
                    SEC_AUTHORITY:  n_ns = cur_dec;
                    SEC_ADDITIONAL: n_ar = cur_dec;
                    default: begin
                    end
                endcase
            end
            n_phase = PH_NAME;
            n_name_len = '0;
            n_label_left = '0;
            n_fcount = '0;
            n_acc = '0;
            priority if (enter_first <= SEC_QUESTION && n_qd != '0) begin
                n_section = SEC_QUESTION;
            end else if (enter_first <= SEC_ANSWER && n_an != '0) begin
                n_section = SEC_ANSWER;
            end else if (enter_first <= SEC_AUTHORITY && n_ns != '0) begin
                n_section = SEC_AUTHORITY;
            end else if (enter_first <= SEC_ADDITIONAL && n_ar != '0) begin
                n_section = SEC_ADDITIONAL;
            end else begin
                n_phase = PH_DONE;
                n_section = c_section;
                res_cnt = res_cnt + 2'd1;
                res1 = '{kind: KIND_DONE, section: c_section, value: '0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_section     <= SEC_HEADER;
            r_fcount      <= '0;
            r_acc         <= '0;
            r_qd          <= '0;
            r_an          <= '0;
            r_ns          <= '0;
            r_ar          <= '0;
            r_name_len    <= '0;
            r_label_left  <= '0;
            r_rdata_left  <= '0;
            r_label_limit <= LABEL_LIMIT_RESET;
            r_name_limit  <= NAME_LIMIT_RESET;
            r_wr_ptr      <= '0;
            r_rd_ptr      <= '0;
            r_q_count     <= '0;
        end else begin
            if (in_fire) begin
                r_phase      <= n_phase;
                r_section    <= n_section;
                r_fcount     <= n_fcount;
                r_acc        <= n_acc;
                r_qd         <= n_qd;
                r_an         <= n_an;
                r_ns         <= n_ns;
                r_ar         <= n_ar;
                r_name_len   <= n_name_len;
                r_label_left <= n_label_left;
                r_rdata_left <= n_rdata_left;
                r_wr_ptr     <= r_wr_ptr + QPTR_W'(res_cnt);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_LABEL_LIMIT) begin
                    r_label_limit <= i_cfg_data[5:0];
                end else if (i_cfg_index == REG_NAME_LIMIT) begin
                    r_name_limit <= i_cfg_data;
                end
            end
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_q_count <= r_q_count + (in_fire ? (QPTR_W+1)'(res_cnt) : '0)
                         - (out_fire ? (QPTR_W+1)'(1) : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && res_cnt != 2'd0) begin
            r_q[r_wr_ptr] <= res0;
        end
        if (in_fire && res_cnt == 2'd2) begin
            r_q[r_wr_ptr + QPTR_W'(1)] <= res1;
        end
    end

    assign head        = r_q[r_rd_ptr];
    assign o_out_valid = (r_q_count != '0);
    assign o_kind      = head.kind;
    assign o_section   = head.section;
    assign o_value     = head.value;

    // flag fields are decoded from the flags word and zero on every other kind
    always_comb begin
        if (head.kind == KIND_FLAGS) begin
            o_is_response         = head.value[15];
            o_op_code             = head.value[14:11];
            o_authoritative       = head.value[10];
            o_truncated           = head.value[9];
            o_recursion_desired   = head.value[8];
            o_recursion_available = head.value[7];
            o_reserved_bits       = head.value[6:4];
            o_response_code       = head.value[3:0];
        end else begin
            o_is_response         = 1'b0;
            o_op_code             = '0;
            o_authoritative       = 1'b0;
            o_truncated           = 1'b0;
            o_recursion_desired   = 1'b0;
            o_recursion_available = 1'b0;
            o_reserved_bits       = '0;
            o_response_code       = '0;
        end
    end

endmodule

// File: rtl/core/dmsp_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dmsp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [dmsp_pkg::KIND_W-1:0]     o_kind,
    input logic [dmsp_pkg::SECTION_W-1:0]  o_section,
    input logic [dmsp_pkg::VALUE_W-1:0]    o_value,
    input logic                            o_is_response,
    input logic [3:0]                      o_op_code,
    input logic                            o_authoritative,
    input logic [3:0]                      o_response_code
);
    import dmsp_pkg::*;

    `DMSP_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_kind) && $stable(o_section) && $stable(o_value), "stalled result changed")
    `DMSP_ASSERT(a_kind_range, o_out_valid, o_kind <= KIND_ERROR, "result kind out of range")
    `DMSP_ASSERT(a_header_section, o_out_valid && o_kind <= KIND_ARCOUNT, o_section == SEC_HEADER, "header field outside header section")
    `DMSP_ASSERT(a_flags_only, o_out_valid && o_kind != KIND_FLAGS, !o_is_response && o_op_code == '0 && !o_authoritative && o_response_code == '0, "flag fields set on non-flags result")

endmodule

bind dns_message_stream_parser dmsp_checker u_dmsp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_kind          (o_kind),
    .o_section       (o_section),
    .o_value         (o_value),
    .o_is_response   (o_is_response),
    .o_op_code       (o_op_code),
    .o_authoritative (o_authoritative),
    .o_response_code (o_response_code)
);
